@@ rtl/core/triangle_index_stream_decoder_macros.svh @@
// Assertion macros shared by the triangle index stream decoder.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef TRIANGLE_INDEX_STREAM_DECODER_MACROS_SVH
`define TRIANGLE_INDEX_STREAM_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TISD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TISD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/tisd_pkg.sv @@
// Types, constants and helper functions for the triangle index stream decoder.
// No dependencies; tisd_decode and triangle_index_stream_decoder import this package.
`timescale 1ns / 1ps

package tisd_pkg;

   localparam int HIST_DEPTH = 16;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);

   localparam logic [7:0]  EDGE_CODE_END  = 8'hF0;
   localparam logic [7:0]  TABLE_CODE_END = 8'hFE;
   localparam logic [7:0]  CODE_FULL_EXPL = 8'hFF;
   localparam logic [3:0]  FEC_LIMIT      = 4'd13;
   localparam logic [3:0]  FIELD_READ     = 4'd15;
   localparam logic [31:0] NEAR_BIAS      = 32'd27;
   localparam logic [31:0] NARROW_LIMIT   = 32'h0001_0000;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_VERT_TOTAL     = 2'd0,
      REG_NARROW_INDICES = 2'd1,
      REG_AUX_TABLE_LOW  = 2'd2,
      REG_AUX_TABLE_HIGH = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      PATH_EDGE,
      PATH_TABLE,
      PATH_EXPLICIT
   } path_type;

   typedef logic [HIST_DEPTH-1:0][63:0] edge_hist_type;
   typedef logic [HIST_DEPTH-1:0][31:0] vert_hist_type;

   typedef struct packed {
      logic [31:0] vert_total;
      logic        narrow_indices;
      logic [63:0] aux_table_low;
      logic [63:0] aux_table_high;
   } cfg_type;

   typedef struct packed {
      logic               first_triangle;
      logic               last_triangle;
      logic [7:0]         code_byte;
      logic [63:0]        window_low;
      logic [63:0]        window_high;
      logic signed [32:0] data_remaining;
   } req_word_type;

   typedef struct packed {
      logic [31:0] index_a;
      logic [31:0] index_b;
      logic [31:0] index_c;
      logic [4:0]  bytes_consumed;
      logic        error;
   } rsp_word_type;

   typedef struct packed {
      logic [HIST_AW-1:0] edge_write_pos;
      logic [HIST_AW-1:0] vertex_write_pos;
      logic [31:0]        next_new_index;
      logic [31:0]        last_explicit_index;
      logic               failed;
   } ctx_type;

   typedef struct packed {
      logic [2:0]  len;
      logic [31:0] value;
   } varint_type;

   // Decode a varint of up to five bytes starting at pos; the window wraps at 16 bytes.
   function automatic varint_type read_varint(logic [127:0] win, logic [4:0] pos);
      varint_type r;
      logic [7:0] b;
      logic       done;
      logic [3:0] idx;
      r.value = '0;
      r.len   = '0;
      done    = 1'b0;
      for (int k = 0; k < 5; k++) begin
         idx = 4'(pos + 5'(k));
         b   = win[{idx, 3'b000} +: 8];
         if (!done) begin
            r.value = r.value | (32'(b[6:0]) << (7 * k));
            r.len   = 3'(k + 1);
            if (!b[7]) begin
               done = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Zigzag decode of a signed delta.
   function automatic logic [31:0] zigzag(logic [31:0] v);
      return (v >> 1) ^ (32'd0 - {31'd0, v[0]});
   endfunction

endpackage

@@ rtl/core/tisd_if.sv @@
// Handshake interfaces for the request, response and configuration channels.
// Depends on tisd_pkg for nothing but field widths written out here.
`timescale 1ns / 1ps

interface tisd_req_if;
   logic               valid;
   logic               ready;
   logic               first_triangle;
   logic               last_triangle;
   logic [7:0]         code_byte;
   logic [63:0]        window_low;
   logic [63:0]        window_high;
   logic signed [32:0] data_remaining;

   modport source (output valid, first_triangle, last_triangle, code_byte,
                   window_low, window_high, data_remaining, input ready);
   modport sink   (input valid, first_triangle, last_triangle, code_byte,
                   window_low, window_high, data_remaining, output ready);
endinterface

interface tisd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] index_a;
   logic [31:0] index_b;
   logic [31:0] index_c;
   logic [4:0]  bytes_consumed;
   logic        error;

   modport source (output valid, index_a, index_b, index_c, bytes_consumed, error,
                   input ready);
   modport sink   (input valid, index_a, index_b, index_c, bytes_consumed, error,
                   output ready);
endinterface

interface tisd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/tisd_decode.sv @@
// Combinational decode of one triangle word against the stream context.
// Depends on tisd_pkg; produces the response word and the next context.
`timescale 1ns / 1ps

module tisd_decode (
   input  tisd_pkg::cfg_type       cfg,
   input  tisd_pkg::req_word_type  word,
   input  tisd_pkg::ctx_type       ctx_i,
   input  tisd_pkg::edge_hist_type edge_hist_i,
   input  tisd_pkg::vert_hist_type vert_hist_i,
   output tisd_pkg::ctx_type       ctx_o,
   output tisd_pkg::edge_hist_type edge_hist_o,
   output tisd_pkg::vert_hist_type vert_hist_o,
   output tisd_pkg::rsp_word_type  rsp_o
);
   import tisd_pkg::*;

   ctx_type            ctx;
   edge_hist_type      eh;
   vert_hist_type      vh;
   path_type           path;
   logic [127:0]       win;
   logic [127:0]       aux_tab;
   logic [31:0]        limit;
   logic [31:0]        a, b, c, n1, n2, nb, lei;
   logic [7:0]         aux;
   logic [3:0]         feb, fec;
   logic               isnew, b0, c0, exa, overrun, out_range, tail_bad;
   logic [4:0]         pos;
   varint_type         vr0, vr1, vr2;
   logic [2:0][31:0]   vval;
   logic [2:0]         ven, vadv;
   logic [2:0][63:0]   eval;
   logic [2:0]         een;
   logic [HIST_AW-1:0] q0, q1, q2, e_start;
   logic signed [33:0] tail_diff;

   always_comb begin
      // A first triangle starts from a cleared context.
      if (word.first_triangle) begin
         ctx = '0;
         eh  = '1;
         vh  = '1;
      end else begin
         ctx = ctx_i;
         eh  = edge_hist_i;
         vh  = vert_hist_i;
      end

      limit   = (cfg.narrow_indices && (cfg.vert_total > NARROW_LIMIT)) ?
                NARROW_LIMIT : cfg.vert_total;
      win     = {word.window_high, word.window_low};
      aux_tab = {cfg.aux_table_high, cfg.aux_table_low};

      if (word.code_byte < EDGE_CODE_END) begin
         path = PATH_EDGE;
      end else if (word.code_byte < TABLE_CODE_END) begin
         path = PATH_TABLE;
      end else begin
         path = PATH_EXPLICIT;
      end

      // Defaults.
      ctx_o   = ctx;
      a = '0; b = '0; c = '0; n1 = '0; n2 = '0; nb = '0;
      lei     = ctx.last_explicit_index;
      aux     = '0;
      feb     = '0;
      fec     = '0;
      isnew   = 1'b0;
      b0      = 1'b0;
      c0      = 1'b0;
      exa     = 1'b0;
      overrun = 1'b0;
      pos     = '0;
      vr0     = read_varint(win, 5'd0);
      vr1     = '0;
      vr2     = '0;
      vval    = '0;
      ven     = '0;
      vadv    = '0;
      een     = 3'b111;
      e_start = ctx.edge_write_pos;

      unique case (path)
         PATH_EDGE: begin
            // Reuse a recent edge; the third vertex is new, cached or explicit.
            fec = word.code_byte[3:0];
            a   = eh[ctx.edge_write_pos - HIST_AW'(1) - word.code_byte[7:4]][31:0];
            b   = eh[ctx.edge_write_pos - HIST_AW'(1) - word.code_byte[7:4]][63:32];
            if (fec < FEC_LIMIT) begin
               isnew = (fec == 4'd0);
               c = isnew ? ctx.next_new_index :
                           vh[ctx.vertex_write_pos - HIST_AW'(1) - fec];
               ctx_o.next_new_index = ctx.next_new_index + 32'(isnew);
               vadv[0] = isnew;
            end else begin
               overrun = word.data_remaining < 0;
               if (fec != FIELD_READ) begin
                  c = lei + 32'({fec, 1'b0}) - NEAR_BIAS;
               end else begin
                  c   = lei + zigzag(vr0.value);
                  pos = 5'(vr0.len);
               end
               ctx_o.last_explicit_index = c;
               vadv[0] = 1'b1;
            end
            vval[0] = c;
            ven[0]  = 1'b1;
            een     = 3'b110;
            e_start = ctx.edge_write_pos - HIST_AW'(1);
         end
         PATH_TABLE: begin
            // Fast code: the aux table supplies both vertex fields.
            aux = aux_tab[{word.code_byte[3:0], 3'b000} +: 8];
            feb = aux[7:4];
            fec = aux[3:0];
            b0  = (feb == 4'd0);
            c0  = (fec == 4'd0);
            a   = ctx.next_new_index;
            n1  = a + 32'd1;
            b   = b0 ? n1 : vh[ctx.vertex_write_pos - feb];
            n2  = n1 + 32'(b0);
            c   = c0 ? n2 : vh[ctx.vertex_write_pos - fec];
            ctx_o.next_new_index = n2 + 32'(c0);
            vval = {c, b, a};
            ven  = 3'b111;
            vadv = {c0, b0, 1'b1};
         end
         PATH_EXPLICIT: begin
            // Explicit code: a field byte from the data, then varint deltas.
            overrun = word.data_remaining < 0;
            aux = win[7:0];
            feb = aux[7:4];
            fec = aux[3:0];
            exa = (word.code_byte == CODE_FULL_EXPL);
            nb  = (aux == 8'd0) ? 32'd0 : ctx.next_new_index;
            a   = exa ? 32'd0 : nb;
            n1  = nb + 32'(!exa);
            b   = (feb == 4'd0) ? n1 : vh[ctx.vertex_write_pos - feb];
            n2  = n1 + 32'(feb == 4'd0);
            c   = (fec == 4'd0) ? n2 : vh[ctx.vertex_write_pos - fec];
            ctx_o.next_new_index = n2 + 32'(fec == 4'd0);
            pos = 5'd1;
            vr0 = read_varint(win, pos);
            if (exa) begin
               lei = lei + zigzag(vr0.value);
               a   = lei;
               pos = pos + 5'(vr0.len);
            end
            vr1 = read_varint(win, pos);
            if (feb == FIELD_READ) begin
               lei = lei + zigzag(vr1.value);
               b   = lei;
               pos = pos + 5'(vr1.len);
            end
            vr2 = read_varint(win, pos);
            if (fec == FIELD_READ) begin
               lei = lei + zigzag(vr2.value);
               c   = lei;
               pos = pos + 5'(vr2.len);
            end
            ctx_o.last_explicit_index = lei;
            vval = {c, b, a};
            ven  = 3'b111;
            vadv = {(fec == 4'd0) || (fec == FIELD_READ),
                    (feb == 4'd0) || (feb == FIELD_READ), 1'b1};
         end
         default: begin
         end
      endcase

      // Vertex history pushes; a later push to the same slot wins.
      q0 = ctx.vertex_write_pos;
      q1 = q0 + HIST_AW'(ven[0] & vadv[0]);
      q2 = q1 + HIST_AW'(ven[1] & vadv[1]);
      ctx_o.vertex_write_pos = q2 + HIST_AW'(ven[2] & vadv[2]);
      vert_hist_o = vh;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         if (ven[0] && (HIST_AW'(i) == q0)) vert_hist_o[i] = vval[0];
         if (ven[1] && (HIST_AW'(i) == q1)) vert_hist_o[i] = vval[1];
         if (ven[2] && (HIST_AW'(i) == q2)) vert_hist_o[i] = vval[2];
      end

      // Edge history pushes: first vertex high, second vertex low.
      eval = {{c, a}, {b, c}, {a, b}};
      edge_hist_o = eh;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         for (int k = 0; k < 3; k++) begin
            if (een[k] && (HIST_AW'(i) == HIST_AW'(e_start + HIST_AW'(k)))) begin
               edge_hist_o[i] = eval[k];
            end
         end
      end
      ctx_o.edge_write_pos = e_start + HIST_AW'(3);

      // Error checks.
      out_range = (a >= limit) || (b >= limit) || (c >= limit);
      tail_diff = 34'(word.data_remaining) - $signed({29'd0, pos});
      tail_bad  = word.last_triangle && (tail_diff != 34'sd0);
      ctx_o.failed = ctx.failed | overrun | out_range | tail_bad;

      rsp_o.index_a        = a;
      rsp_o.index_b        = b;
      rsp_o.index_c        = c;
      rsp_o.bytes_consumed = pos;
      rsp_o.error          = ctx_o.failed;
   end

endmodule

@@ rtl/core/triangle_index_stream_decoder.sv @@
// Triangle index stream decoder: the request word is registered, decoded, and registered again as the response word.
// Throughput one triangle per cycle while response words are taken; the context loop through tisd_decode sets it.
// A stalled response word holds the input register, which then holds off requests.
// Synchronous active-high reset clears configuration, histories to all ones and context.
// No clearing pass: histories are flip-flops reset at once.
`timescale 1ns / 1ps
`include "triangle_index_stream_decoder_macros.svh"

module triangle_index_stream_decoder (
   input logic       clock,
   input logic       reset,
   tisd_req_if.sink  req_ch,
   tisd_rsp_if.source rsp_ch,
   tisd_csr_if.sink  csr_ch
);
   import tisd_pkg::*;

   cfg_type       cfg_ff;
   logic          in_valid_ff, out_valid_ff, advance;
   req_word_type  in_word_ff, req_word;
   rsp_word_type  out_word_ff, rsp_word_in;
   ctx_type       ctx_ff, ctx_in;
   edge_hist_type edge_hist_ff, edge_hist_in;
   vert_hist_type vert_hist_ff, vert_hist_in;

   // Configuration writes are always taken.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (reg_index_type'(csr_ch.index))
            REG_VERT_TOTAL:     cfg_ff.vert_total     <= csr_ch.data[31:0];
            REG_NARROW_INDICES: cfg_ff.narrow_indices <= csr_ch.data[0];
            REG_AUX_TABLE_LOW:  cfg_ff.aux_table_low  <= csr_ch.data;
            REG_AUX_TABLE_HIGH: cfg_ff.aux_table_high <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   // A word is decoded when the output register is free or being emptied.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   assign req_word.first_triangle = req_ch.first_triangle;
   assign req_word.last_triangle  = req_ch.last_triangle;
   assign req_word.code_byte      = req_ch.code_byte;
   assign req_word.window_low     = req_ch.window_low;
   assign req_word.window_high    = req_ch.window_high;
   assign req_word.data_remaining = req_ch.data_remaining;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_word_ff <= req_word;
      end
   end

   tisd_decode u_decode (
      .cfg         (cfg_ff),
      .word        (in_word_ff),
      .ctx_i       (ctx_ff),
      .edge_hist_i (edge_hist_ff),
      .vert_hist_i (vert_hist_ff),
      .ctx_o       (ctx_in),
      .edge_hist_o (edge_hist_in),
      .vert_hist_o (vert_hist_in),
      .rsp_o       (rsp_word_in)
   );

   // Stream context and histories.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff       <= '0;
         edge_hist_ff <= '1;
         vert_hist_ff <= '1;
      end else if (advance) begin
         ctx_ff       <= ctx_in;
         edge_hist_ff <= edge_hist_in;
         vert_hist_ff <= vert_hist_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= rsp_word_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.index_a        = out_word_ff.index_a;
   assign rsp_ch.index_b        = out_word_ff.index_b;
   assign rsp_ch.index_c        = out_word_ff.index_c;
   assign rsp_ch.bytes_consumed = out_word_ff.bytes_consumed;
   assign rsp_ch.error          = out_word_ff.error;

   // Checks on the decoder's own behavior.
   `TISD_ASSERT_NEXT(a_error_sticky, ctx_ff.failed && !(advance && in_word_ff.first_triangle), ctx_ff.failed, "error flag dropped without a first triangle")
   `TISD_ASSERT_SAME(a_bytes_bound, out_valid_ff, out_word_ff.bytes_consumed <= 5'd16, "bytes consumed above window size")
   `TISD_ASSERT_NEXT(a_hold_input, in_valid_ff && !advance, in_valid_ff && $stable(in_word_ff), "held input word changed")
   `TISD_ASSERT_NEXT(a_edge_step, advance && (in_word_ff.code_byte < EDGE_CODE_END) && !in_word_ff.first_triangle, ctx_ff.edge_write_pos == $past(ctx_ff.edge_write_pos) + HIST_AW'(2), "edge pointer step wrong")

endmodule
